// File: design/xxh_pkg.sv
// Shared types, constants and command codes for the XXH64 stream hasher.
package xxh_pkg;

    localparam logic [63:0] PR1 = 64'd11400714785074694791;
    localparam logic [63:0] PR2 = 64'd14029467366897019727;
    localparam logic [63:0] PR3 = 64'd1609587929392839161;
    localparam logic [63:0] PR4 = 64'd9650029242287828579;
    localparam logic [63:0] PR5 = 64'd2870177450012600261;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_INIT      = 4'd1;
    localparam logic [3:0] OP_LANE_ROT  = 4'd2;
    localparam logic [3:0] OP_LANE_WR   = 4'd3;
    localparam logic [3:0] OP_MERGE0    = 4'd4;
    localparam logic [3:0] OP_MERGE_ADD = 4'd5;
    localparam logic [3:0] OP_T_ROT31   = 4'd6;
    localparam logic [3:0] OP_H_XOR     = 4'd7;
    localparam logic [3:0] OP_T_ROT_H   = 4'd8;
    localparam logic [3:0] OP_H_P_ADD   = 4'd9;
    localparam logic [3:0] OP_H_SEED    = 4'd10;
    localparam logic [3:0] OP_H_LEN     = 4'd11;
    localparam logic [3:0] OP_H_AVAL33  = 4'd12;
    localparam logic [3:0] OP_H_XSH29   = 4'd13;
    localparam logic [3:0] OP_OUT       = 4'd14;

    // multiplier operand sources
    localparam logic [2:0] SRC_BUF  = 3'd0;
    localparam logic [2:0] SRC_WORD = 3'd1;
    localparam logic [2:0] SRC_LANE = 3'd2;
    localparam logic [2:0] SRC_T    = 3'd3;
    localparam logic [2:0] SRC_H    = 3'd4;
    localparam logic [2:0] SRC_WLO  = 3'd5;
    localparam logic [2:0] SRC_BYTE = 3'd6;

    // constant selects
    localparam logic [2:0] K_PR1  = 3'd0;
    localparam logic [2:0] K_PR2  = 3'd1;
    localparam logic [2:0] K_PR3  = 3'd2;
    localparam logic [2:0] K_PR4  = 3'd3;
    localparam logic [2:0] K_PR5  = 3'd4;
    localparam logic [2:0] K_ZERO = 3'd5;

    // rotate selects
    localparam logic [1:0] ROT27 = 2'd0;
    localparam logic [1:0] ROT23 = 2'd1;
    localparam logic [1:0] ROT11 = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       mul_start;
        logic [2:0] msrc;
        logic [2:0] ksel;
        logic [1:0] rsel;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       fold;
        logic       last;
        logic       live;
        logic [1:0] fill;
        logic [3:0] cnt;
        logic       out_busy;
        logic       mul_done;
    } t_stat;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] kval(input logic [2:0] sel);
        logic [63:0] k;
        case (sel)
            K_PR1:   k = PR1;
            K_PR2:   k = PR2;
            K_PR3:   k = PR3;
            K_PR4:   k = PR4;
            K_PR5:   k = PR5;
            default: k = 64'd0;
        endcase
        return k;
    endfunction

endpackage

// File: design/xxh64_stream_hasher_core.sv
// Sequencing: a word that only fills the buffer needs no multiply; a word that completes a
//   stripe adds 4 lane rounds of 2 multiplies each, one lane after another.
// Finalization runs all its multiplies on the single shared multiplier.
// Throughput: one beat at a time; the next beat is taken once the controller is idle,
//   while a finished hash may still wait in the output register.
// Reset: synchronous active low; clears seed, length, fill, lane status and valids.
module xxh64_stream_hasher_core import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    // input beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_is_last,
    // result beats
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_value
);
    t_cmd  cmd;
    t_stat stat;
    logic  idle;
    logic  accept;

    // take a beat only while the sequencer is idle
    assign o_stall = !idle;
    assign accept  = i_valid && idle;

    xxh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    xxh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_accept     (accept),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_is_last    (i_is_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_hash_value (o_hash_value)
    );
endmodule

// File: design/xxh_mul.sv
// Multi-cycle 64x64 low-half multiplier built on one 32x32 multiplier.
module xxh_mul import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [63:0] r_a, r_b, r_p;
    logic [1:0]  r_step;
    logic        r_busy, r_done;
    logic [31:0] m_x, m_y;
    logic [63:0] pp;

    always_comb begin
        case (r_step)
            2'd0:    begin m_x = r_a[31:0];  m_y = r_b[31:0];  end
            2'd1:    begin m_x = r_a[31:0];  m_y = r_b[63:32]; end
            default: begin m_x = r_a[63:32]; m_y = r_b[31:0];  end
        endcase
        pp = {32'd0, m_x} * {32'd0, m_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            if (r_step == 2'd0) r_p <= pp;
            else                r_p <= r_p + {pp[31:0], 32'd0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

// File: design/xxh_dp.sv
// Datapath: lanes, stripe buffer, length, hash working registers, output register.
module xxh_dp import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_accept,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_is_last,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [63:0] o_hash_value
);
    logic [63:0] r_seed, r_len, r_word, r_h, r_t, r_out;
    logic [63:0] r_lane [4];
    logic [63:0] r_buf  [3];
    logic [1:0]  r_fill;
    logic [3:0]  r_cnt;
    logic        r_live, r_fold, r_last, r_ovalid;
    logic [63:0] mul_a, p, lane_q, buf_q, rot_h;
    logic        mul_done;
    logic [3:0]  cnt_sat;

    assign cnt_sat = (!i_is_last || i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    assign lane_q  = r_lane[i_cmd.idx[1:0]];

    always_comb begin
        case (i_cmd.idx[1:0])
            2'd0:    buf_q = r_buf[0];
            2'd1:    buf_q = r_buf[1];
            default: buf_q = r_buf[2];
        endcase
        case (i_cmd.msrc)
            SRC_BUF:  mul_a = buf_q;
            SRC_WORD: mul_a = r_word;
            SRC_LANE: mul_a = lane_q;
            SRC_T:    mul_a = r_t;
            SRC_H:    mul_a = r_h;
            SRC_WLO:  mul_a = {32'd0, r_word[31:0]};
            SRC_BYTE: mul_a = {56'd0, r_word[{i_cmd.idx, 3'b000} +: 8]};
            default:  mul_a = 64'd0;
        endcase
        case (i_cmd.rsel)
            ROT27:   rot_h = rotl64(r_h, 27);
            ROT23:   rot_h = rotl64(r_h, 23);
            default: rot_h = rotl64(r_h, 11);
        endcase
    end

    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (kval(i_cmd.ksel)),
        .o_done  (mul_done),
        .o_prod  (p)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= 64'd0;
            r_len    <= 64'd0;
            r_fill   <= 2'd0;
            r_live   <= 1'b0;
            r_fold   <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_seed <= i_cfg_wdata;
            if (r_ovalid && !i_stall && i_cmd.op != OP_OUT) r_ovalid <= 1'b0;
            if (i_accept) begin
                r_len  <= r_len + {60'd0, cnt_sat};
                r_last <= i_is_last;
                r_fold <= (cnt_sat == 4'd8) && (r_fill == 2'd3);
                if (cnt_sat == 4'd8) begin
                    r_fill <= (r_fill == 2'd3) ? 2'd0 : r_fill + 2'd1;
                end
            end
            case (i_cmd.op)
                OP_INIT: r_live <= 1'b1;
                OP_OUT: begin
                    r_ovalid <= 1'b1;
                    r_fill   <= 2'd0;
                    r_len    <= 64'd0;
                    r_live   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word <= i_data_word;
            r_cnt  <= cnt_sat;
            if (cnt_sat == 4'd8 && r_fill != 2'd3) r_buf[r_fill] <= i_data_word;
        end
        case (i_cmd.op)
            OP_INIT: begin
                if (!r_live) begin
                    r_lane[0] <= r_seed + PR1 + PR2;
                    r_lane[1] <= r_seed + PR2;
                    r_lane[2] <= r_seed;
                    r_lane[3] <= r_seed - PR1;
                end
            end
            OP_LANE_ROT:  r_h <= rotl64(lane_q + p, 31);
            OP_LANE_WR:   r_lane[i_cmd.idx[1:0]] <= p;
            OP_MERGE0:    r_h <= rotl64(r_lane[0], 1) + rotl64(r_lane[1], 7);
            OP_MERGE_ADD: r_h <= r_h + ((i_cmd.idx[1:0] == 2'd3) ?
                                        rotl64(lane_q, 18) : rotl64(lane_q, 12));
            OP_T_ROT31:   r_t <= rotl64(p, 31);
            OP_H_XOR:     r_h <= r_h ^ p;
            OP_T_ROT_H:   r_t <= rot_h;
            OP_H_P_ADD:   r_h <= p + kval(i_cmd.ksel);
            OP_H_SEED:    r_h <= r_seed + PR5;
            OP_H_LEN:     r_h <= r_h + r_len;
            OP_H_AVAL33:  r_h <= r_h ^ (r_h >> 33);
            OP_H_XSH29:   r_h <= p ^ (p >> 29);
            OP_OUT:       r_out <= p ^ (p >> 32);
            default: ;
        endcase
    end

    always_comb begin
        o_stat.fold     = r_fold;
        o_stat.last     = r_last;
        o_stat.live     = r_live;
        o_stat.fill     = r_fill;
        o_stat.cnt      = r_cnt;
        o_stat.out_busy = r_ovalid && i_stall;
        o_stat.mul_done = mul_done;
    end

    assign o_valid      = r_ovalid;
    assign o_hash_value = r_out;
endmodule

// File: design/xxh_ctrl.sv
// Controller: sequences stripe folds and the finalization steps.
module xxh_ctrl import xxh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle
);
    localparam logic [5:0] S_IDLE = 6'd0,  S_DECIDE = 6'd1,  S_F_M1 = 6'd2,  S_F_A = 6'd3,
                           S_F_M2 = 6'd4,  S_F_W = 6'd5,     S_POST = 6'd6,  S_MRG0 = 6'd7,
                           S_MRG2 = 6'd8,  S_MRG3 = 6'd9,    S_R_M1 = 6'd10, S_R_T = 6'd11,
                           S_R_M2 = 6'd12, S_R_X = 6'd13,    S_R_M3 = 6'd14, S_R_A = 6'd15,
                           S_SEED = 6'd16, S_LEN = 6'd17,    S_B_CHK = 6'd18, S_B_M1 = 6'd19,
                           S_B_T = 6'd20,  S_B_M2 = 6'd21,   S_B_X = 6'd22,  S_B_R = 6'd23,
                           S_B_M3 = 6'd24, S_B_A = 6'd25,    S_TAIL = 6'd26, S_W_M1 = 6'd27,
                           S_W_X = 6'd28,  S_W_R = 6'd29,    S_W_M2 = 6'd30, S_W_A = 6'd31,
                           S_Y_CHK = 6'd32, S_Y_M1 = 6'd33,  S_Y_X = 6'd34,  S_Y_R = 6'd35,
                           S_Y_M2 = 6'd36, S_Y_A = 6'd37,    S_V1 = 6'd38,   S_V_M1 = 6'd39,
                           S_V2 = 6'd40,   S_V_M2 = 6'd41,   S_OUT = 6'd42;

    logic [5:0] r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_mwait, n_mwait;
    logic       is_mul, mul_fin;

    assign mul_fin = r_mwait && i_stat.mul_done;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        is_mul  = 1'b0;
        o_cmd   = '0;
        o_cmd.op  = OP_NONE;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.fold) begin
                    o_cmd.op = OP_INIT;
                    n_idx    = 3'd0;
                    n_state  = S_F_M1;
                end else begin
                    n_state = S_POST;
                end
            end
            S_F_M1: begin
                is_mul     = 1'b1;
                o_cmd.msrc = (r_idx[1:0] == 2'd3) ? SRC_WORD : SRC_BUF;
                o_cmd.ksel = K_PR2;
                if (mul_fin) n_state = S_F_A;
            end
            S_F_A: begin
                o_cmd.op = OP_LANE_ROT;
                n_state  = S_F_M2;
            end
            S_F_M2: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_H;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_F_W;
            end
            S_F_W: begin
                o_cmd.op = OP_LANE_WR;
                n_idx    = r_idx + 3'd1;
                n_state  = (r_idx[1:0] == 2'd3) ? S_POST : S_F_M1;
            end
            S_POST: begin
                if (!i_stat.last)     n_state = S_IDLE;
                else if (i_stat.live) n_state = S_MRG0;
                else                  n_state = S_SEED;
            end
            S_MRG0: begin
                o_cmd.op = OP_MERGE0;
                n_idx    = 3'd2;
                n_state  = S_MRG2;
            end
            S_MRG2: begin
                o_cmd.op = OP_MERGE_ADD;
                n_idx    = 3'd3;
                n_state  = S_MRG3;
            end
            S_MRG3: begin
                o_cmd.op = OP_MERGE_ADD;
                n_idx    = 3'd0;
                n_state  = S_R_M1;
            end
            S_R_M1: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_LANE;
                o_cmd.ksel = K_PR2;
                if (mul_fin) n_state = S_R_T;
            end
            S_R_T: begin
                o_cmd.op = OP_T_ROT31;
                n_state  = S_R_M2;
            end
            S_R_M2: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_T;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_R_X;
            end
            S_R_X: begin
                o_cmd.op = OP_H_XOR;
                n_state  = S_R_M3;
            end
            S_R_M3: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_H;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_R_A;
            end
            S_R_A: begin
                o_cmd.op   = OP_H_P_ADD;
                o_cmd.ksel = K_PR4;
                n_idx      = r_idx + 3'd1;
                n_state    = (r_idx[1:0] == 2'd3) ? S_LEN : S_R_M1;
            end
            S_SEED: begin
                o_cmd.op = OP_H_SEED;
                n_state  = S_LEN;
            end
            S_LEN: begin
                o_cmd.op = OP_H_LEN;
                n_idx    = 3'd0;
                n_state  = S_B_CHK;
            end
            S_B_CHK: n_state = (r_idx[1:0] < i_stat.fill) ? S_B_M1 : S_TAIL;
            S_B_M1: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_BUF;
                o_cmd.ksel = K_PR2;
                if (mul_fin) n_state = S_B_T;
            end
            S_B_T: begin
                o_cmd.op = OP_T_ROT31;
                n_state  = S_B_M2;
            end
            S_B_M2: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_T;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_B_X;
            end
            S_B_X: begin
                o_cmd.op = OP_H_XOR;
                n_state  = S_B_R;
            end
            S_B_R: begin
                o_cmd.op   = OP_T_ROT_H;
                o_cmd.rsel = ROT27;
                n_state    = S_B_M3;
            end
            S_B_M3: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_T;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_B_A;
            end
            S_B_A: begin
                o_cmd.op   = OP_H_P_ADD;
                o_cmd.ksel = K_PR4;
                n_idx      = r_idx + 3'd1;
                n_state    = S_B_CHK;
            end
            S_TAIL: begin
                n_idx = 3'd0;
                if (i_stat.cnt < 4'd8 && i_stat.cnt >= 4'd4) n_state = S_W_M1;
                else                                         n_state = S_Y_CHK;
            end
            S_W_M1: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_WLO;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_W_X;
            end
            S_W_X: begin
                o_cmd.op = OP_H_XOR;
                n_state  = S_W_R;
            end
            S_W_R: begin
                o_cmd.op   = OP_T_ROT_H;
                o_cmd.rsel = ROT23;
                n_state    = S_W_M2;
            end
            S_W_M2: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_T;
                o_cmd.ksel = K_PR2;
                if (mul_fin) n_state = S_W_A;
            end
            S_W_A: begin
                o_cmd.op   = OP_H_P_ADD;
                o_cmd.ksel = K_PR3;
                n_idx      = 3'd4;
                n_state    = S_Y_CHK;
            end
            S_Y_CHK: begin
                if (i_stat.cnt < 4'd8 && {1'b0, r_idx} < i_stat.cnt) n_state = S_Y_M1;
                else                                                  n_state = S_V1;
            end
            S_Y_M1: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_BYTE;
                o_cmd.ksel = K_PR5;
                if (mul_fin) n_state = S_Y_X;
            end
            S_Y_X: begin
                o_cmd.op = OP_H_XOR;
                n_state  = S_Y_R;
            end
            S_Y_R: begin
                o_cmd.op   = OP_T_ROT_H;
                o_cmd.rsel = ROT11;
                n_state    = S_Y_M2;
            end
            S_Y_M2: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_T;
                o_cmd.ksel = K_PR1;
                if (mul_fin) n_state = S_Y_A;
            end
            S_Y_A: begin
                o_cmd.op   = OP_H_P_ADD;
                o_cmd.ksel = K_ZERO;
                n_idx      = r_idx + 3'd1;
                n_state    = S_Y_CHK;
            end
            S_V1: begin
                o_cmd.op = OP_H_AVAL33;
                n_state  = S_V_M1;
            end
            S_V_M1: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_H;
                o_cmd.ksel = K_PR2;
                if (mul_fin) n_state = S_V2;
            end
            S_V2: begin
                o_cmd.op = OP_H_XSH29;
                n_state  = S_V_M2;
            end
            S_V_M2: begin
                is_mul     = 1'b1;
                o_cmd.msrc = SRC_H;
                o_cmd.ksel = K_PR3;
                if (mul_fin) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // start the multiplier once per multiply state, then wait for it
        n_mwait = r_mwait;
        if (is_mul) begin
            o_cmd.mul_start = !r_mwait;
            if (!r_mwait)     n_mwait = 1'b1;
            else if (mul_fin) n_mwait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 3'd0;
            r_mwait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_mwait <= n_mwait;
        end
    end

    assign o_idle = (r_state == S_IDLE);
endmodule

// File: design/xxh_chk.sv
// Port-level checker for the hasher core, bound to the top level.
module xxh_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_hash_value
);
    // an accepted beat leaves the block busy in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("accepted beat not held off");

    // a new hash only appears out of a busy block
    a_rise_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)) else $error("hash appeared while idle");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_hash_value)) else $error("result changed");
endmodule

bind xxh64_stream_hasher_core xxh_chk u_xxh_chk (.*);

// File: tb/xxh64_stream_hasher_core_tb.sv
// Self-checking testbench for the XXH64 stream hasher core: directed table, seed changes, random messages, long hold.
`timescale 1ns / 100ps

module xxh64_stream_hasher_core_tb import xxh_pkg::*; ();

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 900000;
    localparam int TAIL_CYCLES = 400;

    // Sentinel for directed rows whose hash comes from the predictor.
    localparam logic [63:0] NO_FIXED = 64'hFFFF_FFFF_FFFF_FFFF;
    // XXH64 of the empty message with seed 0.
    localparam logic [63:0] EMPTY_HASH = 64'hEF46DB3751D8E999;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] in_word = '0;
    logic [3:0]  in_count = '0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_hash;

    xxh64_stream_hasher_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_data_word  (in_word),
        .i_byte_count (in_count),
        .i_is_last    (in_last),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_hash_value (out_hash)
    );

    always #CLK_HALF clk = ~clk;

    // Hasher state mirrored in the testbench.
    logic [63:0] mdl_seed;
    logic [63:0] mdl_lane [4];
    logic [63:0] mdl_buf [3];
    int unsigned mdl_fill;
    logic [63:0] mdl_len;
    bit          mdl_live;

    logic [63:0] hash_queue [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    int          hold_cycles = 0;
    longint      cycle_count = 0;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        rotl = (r == 0) ? x : ((x << r) | (x >> (64 - r)));
    endfunction

    function automatic logic [63:0] lane_round(input logic [63:0] acc, input logic [63:0] w);
        logic [63:0] a;
        a = acc + w * PR2;
        lane_round = rotl(a, 31) * PR1;
    endfunction

    function automatic void clear_msg();
        for (int i = 0; i < 4; i++) mdl_lane[i] = '0;
        for (int i = 0; i < 3; i++) mdl_buf[i] = '0;
        mdl_fill = 0;
        mdl_len  = '0;
        mdl_live = 1'b0;
    endfunction

    // Advance the mirror by one beat; return 1 with the hash when the message ends.
    function automatic bit hash_beat(input logic [63:0] word, input logic [3:0] cnt_in,
                                     input bit last, output logic [63:0] h);
        int unsigned cnt;
        int unsigned pos;
        cnt = cnt_in;
        h = '0;
        if (!last || cnt > 8) cnt = 8;
        mdl_len += 64'(cnt);
        if (cnt == 8) begin
            if (mdl_fill == 3) begin
                if (!mdl_live) begin
                    mdl_lane[0] = mdl_seed + PR1 + PR2;
                    mdl_lane[1] = mdl_seed + PR2;
                    mdl_lane[2] = mdl_seed;
                    mdl_lane[3] = mdl_seed - PR1;
                    mdl_live = 1'b1;
                end
                for (int i = 0; i < 3; i++) mdl_lane[i] = lane_round(mdl_lane[i], mdl_buf[i]);
                mdl_lane[3] = lane_round(mdl_lane[3], word);
                mdl_fill = 0;
            end else begin
                mdl_buf[mdl_fill] = word;
                mdl_fill++;
            end
        end
        if (!last) return 1'b0;
        if (mdl_live) begin
            h = rotl(mdl_lane[0], 1) + rotl(mdl_lane[1], 7) +
                rotl(mdl_lane[2], 12) + rotl(mdl_lane[3], 18);
            for (int i = 0; i < 4; i++) h = (h ^ lane_round('0, mdl_lane[i])) * PR1 + PR4;
        end else begin
            h = mdl_seed + PR5;
        end
        h += mdl_len;
        for (int i = 0; i < mdl_fill; i++) begin
            h ^= lane_round('0, mdl_buf[i]);
            h = rotl(h, 27) * PR1 + PR4;
        end
        if (cnt < 8) begin
            pos = 0;
            if (cnt >= 4) begin
                h ^= {32'd0, word[31:0]} * PR1;
                h = rotl(h, 23) * PR2 + PR3;
                pos = 4;
            end
            for (; pos < cnt; pos++) begin
                h ^= {56'd0, word[8*pos +: 8]} * PR5;
                h = rotl(h, 11) * PR1;
            end
        end
        h ^= h >> 33;
        h *= PR2;
        h ^= h >> 29;
        h *= PR3;
        h ^= h >> 32;
        clear_msg();
        return 1'b1;
    endfunction

    // Drive one beat, hold it until taken, and queue the predicted hash.
    // Valid stays high after the beat is taken; an idle slot or a drain drops it.
    task automatic send_beat(input logic [63:0] word, input logic [3:0] cnt, input bit last,
                             input logic [63:0] fixed);
        logic [63:0] h;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= word;
        in_count <= cnt;
        in_last  <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (hash_beat(word, cnt, last, h)) begin
            if (fixed != NO_FIXED && fixed != h) begin
                $display("%0t predictor disagrees with table: expected %h, predicted %h",
                         $time, fixed, h);
                errors++;
            end
            hash_queue.push_back(h);
        end
    endtask

    // Wait for the block to drain before touching the seed.
    task automatic drain();
        in_valid <= 1'b0;
        while (hash_queue.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mdl_seed = value;
    endtask

    // One message of random content; mostly full words, ending with a random tail.
    task automatic send_message(input int unsigned n_full);
        logic [63:0] w;
        for (int i = 0; i < n_full; i++) begin
            w = {$urandom, $urandom};
            send_beat(w, 4'($urandom_range(15)), 1'b0, NO_FIXED);
        end
        w = {$urandom, $urandom};
        send_beat(w, 4'($urandom_range(15)), 1'b1, NO_FIXED);
    endtask

    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        bit          last;
        logic [63:0] fixed;
    } t_row;

    t_row table_rows [$];

    // Receiver: random stall, or a long hold counted here.
    always @(posedge clk) begin
        if (recv_hold) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each result beat against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (hash_queue.size() == 0) begin
                $display("%0t unexpected hash: expected none, actual %h", $time, out_hash);
                errors++;
            end else begin
                logic [63:0] exp_h;
                exp_h = hash_queue.pop_front();
                if (exp_h !== out_hash) begin
                    $display("%0t hash mismatch: expected %h, actual %h",
                             $time, exp_h, out_hash);
                    errors++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("xxh64_stream_hasher_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        mdl_seed = '0;
        clear_msg();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty message, byte-count cases, stripe edges, extremes.
        table_rows.push_back('{64'h0, 4'd0, 1'b1, EMPTY_HASH});
        table_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, NO_FIXED});
        table_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, NO_FIXED});
        table_rows.push_back('{64'hFFFF_FFFF_FFFF_FF61, 4'd1, 1'b1, NO_FIXED});
        table_rows.push_back('{64'hA5A5_A5A5_1234_5678, 4'd4, 1'b1, NO_FIXED});
        table_rows.push_back('{64'h0123_4567_89AB_CDEF, 4'd7, 1'b1, NO_FIXED});
        table_rows.push_back('{64'h0, 4'd9, 1'b1, NO_FIXED});
        // three non-last words (count ignored) then a last word completing a stripe
        table_rows.push_back('{64'h1111_1111_1111_1111, 4'd0, 1'b0, NO_FIXED});
        table_rows.push_back('{64'h2222_2222_2222_2222, 4'd3, 1'b0, NO_FIXED});
        table_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, NO_FIXED});
        table_rows.push_back('{64'h4444_4444_4444_4444, 4'd8, 1'b1, NO_FIXED});
        // stripe, then a partial stripe and a short tail
        for (int i = 0; i < 6; i++)
            table_rows.push_back('{64'h0 - 64'(i), 4'd8, 1'b0, NO_FIXED});
        table_rows.push_back('{64'h0000_0000_00C3_B2A1, 4'd3, 1'b1, NO_FIXED});
        table_rows.push_back('{64'h8000_0000_0000_0001, 4'd5, 1'b1, NO_FIXED});
        table_rows.push_back('{64'h0, 4'd2, 1'b1, NO_FIXED});
        table_rows.push_back('{64'h7FFF_FFFF_FFFF_FFFE, 4'd6, 1'b1, NO_FIXED});
        foreach (table_rows[i])
            send_beat(table_rows[i].word, table_rows[i].cnt, table_rows[i].last,
                      table_rows[i].fixed);
        drain();

        // Seed changed mid-message: first part before any stripe fold.
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(64'hDEAD_BEEF_0000_0001, 4'd8, 1'b0, NO_FIXED);
        drain();
        write_seed(64'h8000_0000_0000_0000);
        for (int i = 0; i < 4; i++) send_beat({$urandom, $urandom}, 4'd8, 1'b0, NO_FIXED);
        send_beat(64'h55, 4'd1, 1'b1, NO_FIXED);
        drain();

        // Random phases over several seeds and idling patterns.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 31; recv_idle_pct = 68; write_seed(64'd1); end
                1: begin send_idle_pct = 68; recv_idle_pct = 31;
                         write_seed({$urandom, $urandom}); end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; write_seed(64'd0); end
            endcase
            for (int m = 0; m < 32; m++) begin
                if (m % 8 == 7) send_message($urandom_range(9, 14));
                else            send_message($urandom_range(0, 5));
                if (phase == 1 && m == 20) begin
                    // Pause the sender until every hash has arrived.
                    in_valid <= 1'b0;
                    while (hash_queue.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        // Long receiver hold while the sender keeps offering beats.
        fork
            begin
                recv_hold = 1'b1;
                while (hold_cycles < 600) @(posedge clk);
                recv_hold = 1'b0;
            end
            for (int m = 0; m < 4; m++) send_message($urandom_range(0, 2));
        join
        drain();

        if (errors == 0 && hash_queue.size() == 0) begin
            $display("xxh64_stream_hasher_core_tb OK");
        end else begin
            $display("xxh64_stream_hasher_core_tb NOT OK");
        end
        $finish;
    end

endmodule
